>>> rtl/assert_macros.svh
// Assertion macros for the pitch period detector RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ppd_pkg.sv
// Shared constants, types and helpers of the pitch period detector.
// No dependencies.
package ppd_pkg;

  localparam int unsigned MAX_PERIOD  = 4096;
  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned CNT_W       = $clog2(MAX_PERIOD + 1);
  localparam int unsigned DC_LEAK     = 3355;
  localparam int unsigned PERIOD_TOL  = 50;
  localparam int unsigned COUNT_MAX   = 65535;
  localparam int unsigned SUM_MAX     = 268435455;

  localparam int unsigned MUL_A_W = 40;
  localparam int unsigned MUL_B_W = 21;
  localparam int unsigned MUL_H_W = MUL_A_W / 2;
  localparam int unsigned PROD_W  = MUL_H_W + 1 + MUL_B_W;
  localparam int unsigned ACC_W   = MUL_A_W + MUL_B_W;

  localparam logic [2:0] CFG_FILTER_COEF = 3'd0;
  localparam logic [2:0] CFG_DAMPING     = 3'd1;
  localparam logic [2:0] CFG_BANDPASS    = 3'd2;
  localparam logic [2:0] CFG_MIN_AMP     = 3'd3;
  localparam logic [2:0] CFG_ENV_THR     = 3'd4;
  localparam logic [2:0] CFG_ENV_DECAY   = 3'd5;
  localparam logic [2:0] CFG_MIN_PERIOD  = 3'd6;

  typedef struct packed {
    logic mul_lo;
    logic mul_hi;
    logic acc_sum;
  } mac_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sh0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -48'sh0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] amp_of(input logic signed [31:0] pos,
                                         input logic signed [31:0] neg);
    logic signed [32:0] diff;
    logic signed [20:0] a;
    logic [15:0] r;
    diff = 33'(pos) - 33'(neg);
    a = diff[32:12];
    if (a < 0) begin
      r = 16'd0;
    end else if (a > 21'sd65535) begin
      r = 16'hFFFF;
    end else begin
      r = a[15:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/ppd_mac.sv
// Shared signed multiply-accumulate unit: a wide operand in two halves.
// Depends on ppd_pkg.
module ppd_mac (
  input  logic                                  clk_i,
  input  logic signed [ppd_pkg::MUL_A_W-1:0]    a_i,
  input  logic signed [ppd_pkg::MUL_B_W-1:0]    b_i,
  input  ppd_pkg::mac_ctl_t                     ctl_i,
  output logic signed [ppd_pkg::ACC_W-1:0]      acc_o
);

  logic signed [ppd_pkg::MUL_H_W:0]    a_half;
  logic signed [ppd_pkg::PROD_W-1:0]   prod;
  logic signed [ppd_pkg::PROD_W-1:0]   p_q;
  logic signed [ppd_pkg::ACC_W-1:0]    acc_q;

  always_comb begin
    if (ctl_i.mul_hi) begin
      a_half = {a_i[ppd_pkg::MUL_A_W-1], a_i[ppd_pkg::MUL_A_W-1:ppd_pkg::MUL_H_W]};
    end else begin
      a_half = {1'b0, a_i[ppd_pkg::MUL_H_W-1:0]};
    end
  end

  assign prod = ppd_pkg::PROD_W'(a_half * b_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_lo || ctl_i.mul_hi) begin
      p_q <= prod;
    end
    if (ctl_i.mul_hi) begin
      acc_q <= ppd_pkg::ACC_W'(p_q);
    end else if (ctl_i.acc_sum) begin
      acc_q <= acc_q + (ppd_pkg::ACC_W'(p_q) <<< ppd_pkg::MUL_H_W);
    end
  end

  assign acc_o = acc_q;

endmodule

>>> rtl/pitch_period_detector.sv
// Pitch period detector top level: DC high pass, state variable filter,
// envelopes, Schmitt trigger and period accumulation. Uses ppd_pkg, ppd_mac.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i/in_ready_o    sample_i, restart_i
//   out       output     out_valid_o/out_ready_i  filtered_o .. period_sum_o
//   cfg       input      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// Each sample runs through an accept, eight products on the shared multiplier
// (phases low half, high half, sum, write back for each), and a finish.
// The next sample is taken once the finish has loaded the output register.
// The finish waits while a previous result is not yet taken.
// Reset clears all filter, envelope and period state and sets register defaults.
`include "assert_macros.svh"

module pitch_period_detector (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [ppd_pkg::SAMPLE_BITS-1:0]       sample_i,
  input  logic                                  restart_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [15:0]                    filtered_o,
  output logic [15:0]                           amplitude_o,
  output logic [ppd_pkg::CNT_W-1:0]             period_o,
  output logic                                  edge_taken_o,
  output logic [15:0]                           period_count_o,
  output logic [27:0]                           period_sum_o,
  input  logic                                  cfg_we_i,
  input  logic [2:0]                            cfg_idx_i,
  input  logic [19:0]                           cfg_wdata_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam logic [2:0] STEP_DC     = 3'd0;
  localparam logic [2:0] STEP_LOW    = 3'd1;
  localparam logic [2:0] STEP_DAMP   = 3'd2;
  localparam logic [2:0] STEP_BAND   = 3'd3;
  localparam logic [2:0] STEP_POS    = 3'd4;
  localparam logic [2:0] STEP_NEG    = 3'd5;
  localparam logic [2:0] STEP_THR_HI = 3'd6;
  localparam logic [2:0] STEP_THR_LO = 3'd7;

  localparam logic [1:0] PH_LO  = 2'd0;
  localparam logic [1:0] PH_HI  = 2'd1;
  localparam logic [1:0] PH_SUM = 2'd2;
  localparam logic [1:0] PH_WB  = 2'd3;

  localparam int unsigned CW = ppd_pkg::CNT_W;

  logic [15:0] coef_q;
  logic [14:0] damp_q;
  logic        bp_q;
  logic [11:0] min_amp_q;
  logic [15:0] thr_q;
  logic [19:0] decay_q;
  logic [12:0] min_per_q;

  logic [1:0] state_q;
  logic [2:0] step_q;
  logic [1:0] ph_q;

  logic signed [ppd_pkg::MUL_A_W-1:0] dc_q, hp_q, t_q;
  logic signed [31:0] band_q, low_q, pos_q, neg_q;
  logic [15:0] amp_q;
  logic        pulse_q, up_q, dn_q, hi_q, lo_q;
  logic [CW-1:0] cnt_q, pv_q, prev_q;
  logic [15:0] count_q;
  logic [27:0] sum_q;

  logic signed [31:0] y;
  logic signed [ppd_pkg::MUL_A_W-1:0] mul_a;
  logic signed [ppd_pkg::MUL_B_W-1:0] mul_b;
  logic signed [ppd_pkg::ACC_W-1:0]   acc;
  ppd_pkg::mac_ctl_t mac_ctl;
  logic run, wb, fin_go, accept;

  logic edge_w;
  logic [CW-1:0] cnt_tmp, cnt_d, pv_d, prev_d, diff;
  logic [15:0] count_d;
  logic [27:0] sum_d;
  logic [28:0] sum_w;
  logic        pulse_d;
  logic signed [19:0] lim_w;
  logic [15:0] filt_w;

  assign run    = (state_q == ST_RUN);
  assign wb     = run && (ph_q == PH_WB);
  assign accept = in_valid_i && in_ready_o;
  assign fin_go = (state_q == ST_FIN) && (!out_valid_o || out_ready_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign y = bp_q ? band_q : low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q    <= 16'd4096;
      damp_q    <= 15'd8192;
      bp_q      <= 1'b0;
      min_amp_q <= 12'd100;
      thr_q     <= 16'd52429;
      decay_q   <= 20'd1820;
      min_per_q <= 13'd48;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ppd_pkg::CFG_FILTER_COEF: coef_q    <= cfg_wdata_i[15:0];
        ppd_pkg::CFG_DAMPING:     damp_q    <= cfg_wdata_i[14:0];
        ppd_pkg::CFG_BANDPASS:    bp_q      <= cfg_wdata_i[0];
        ppd_pkg::CFG_MIN_AMP:     min_amp_q <= cfg_wdata_i[11:0];
        ppd_pkg::CFG_ENV_THR:     thr_q     <= cfg_wdata_i[15:0];
        ppd_pkg::CFG_ENV_DECAY:   decay_q   <= cfg_wdata_i;
        ppd_pkg::CFG_MIN_PERIOD:  min_per_q <= cfg_wdata_i[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (step_q)
      STEP_DC: begin
        mul_a = hp_q;
        mul_b = ppd_pkg::MUL_B_W'(ppd_pkg::DC_LEAK);
      end
      STEP_LOW: begin
        mul_a = ppd_pkg::MUL_A_W'(band_q);
        mul_b = {5'd0, coef_q};
      end
      STEP_DAMP: begin
        mul_a = ppd_pkg::MUL_A_W'(band_q);
        mul_b = {6'd0, damp_q};
      end
      STEP_BAND: begin
        mul_a = t_q;
        mul_b = {5'd0, coef_q};
      end
      STEP_POS: begin
        mul_a = ppd_pkg::MUL_A_W'(pos_q);
        mul_b = {1'b0, decay_q};
      end
      STEP_NEG: begin
        mul_a = ppd_pkg::MUL_A_W'(neg_q);
        mul_b = {1'b0, decay_q};
      end
      STEP_THR_HI: begin
        mul_a = ppd_pkg::MUL_A_W'(pos_q);
        mul_b = {5'd0, thr_q};
      end
      default: begin
        mul_a = ppd_pkg::MUL_A_W'(neg_q);
        mul_b = {5'd0, thr_q};
      end
    endcase
  end

  assign mac_ctl.mul_lo  = run && (ph_q == PH_LO);
  assign mac_ctl.mul_hi  = run && (ph_q == PH_HI);
  assign mac_ctl.acc_sum = run && (ph_q == PH_SUM);

  ppd_mac u_mac (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .ctl_i (mac_ctl),
    .acc_o (acc)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hp_q <= ppd_pkg::MUL_A_W'({sample_i, 24'd0}) - dc_q;
    end
    if (wb && step_q == STEP_DAMP) begin
      t_q <= ppd_pkg::MUL_A_W'(48'(hp_q >>> 12) - 48'(acc >>> 14) - 48'(low_q));
    end
  end

  always_comb begin
    edge_w  = hi_q && !pulse_q && (13'(cnt_q) >= min_per_q);
    diff    = (prev_q > cnt_q) ? prev_q - cnt_q : cnt_q - prev_q;
    sum_w   = {1'b0, sum_q} + 29'(cnt_q);
    pv_d    = pv_q;
    prev_d  = prev_q;
    count_d = count_q;
    sum_d   = sum_q;
    cnt_tmp = cnt_q;
    if (edge_w) begin
      if (amp_q > 16'(min_amp_q)) begin
        pv_d = cnt_q;
        if (diff < CW'(ppd_pkg::PERIOD_TOL)) begin
          sum_d = (sum_w > 29'(ppd_pkg::SUM_MAX)) ? 28'(ppd_pkg::SUM_MAX) : sum_w[27:0];
          if (count_q != 16'(ppd_pkg::COUNT_MAX)) begin
            count_d = count_q + 16'd1;
          end
        end
        prev_d = cnt_q;
      end else begin
        pv_d = '0;
      end
      cnt_tmp = '0;
    end
    pulse_d = pulse_q;
    if (hi_q) begin
      pulse_d = 1'b1;
    end
    if (lo_q) begin
      pulse_d = 1'b0;
    end
    if (cnt_tmp < CW'(ppd_pkg::MAX_PERIOD)) begin
      cnt_d = cnt_tmp + CW'(1);
    end else begin
      cnt_d = cnt_tmp;
      pv_d  = '0;
    end
    lim_w = y[31:12];
    if (lim_w > 20'sd32767) begin
      filt_w = 16'h7FFF;
    end else if (lim_w < -20'sd32768) begin
      filt_w = 16'h8000;
    end else begin
      filt_w = lim_w[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STEP_DC;
      ph_q    <= PH_LO;
      dc_q    <= '0;
      band_q  <= '0;
      low_q   <= '0;
      pos_q   <= '0;
      neg_q   <= '0;
      amp_q   <= '0;
      pulse_q <= 1'b0;
      up_q    <= 1'b0;
      dn_q    <= 1'b0;
      hi_q    <= 1'b0;
      lo_q    <= 1'b0;
      cnt_q   <= '0;
      pv_q    <= '0;
      prev_q  <= '0;
      count_q <= '0;
      sum_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_RUN;
            step_q  <= STEP_DC;
            ph_q    <= PH_LO;
            if (restart_i) begin
              prev_q  <= '0;
              count_q <= '0;
              sum_q   <= '0;
            end
          end
        end
        ST_RUN: begin
          ph_q <= ph_q + 2'd1;
          if (ph_q == PH_LO && step_q == STEP_NEG && up_q) begin
            amp_q <= ppd_pkg::amp_of(pos_q, neg_q);
          end
          if (ph_q == PH_LO && step_q == STEP_THR_HI && dn_q) begin
            amp_q <= ppd_pkg::amp_of(pos_q, neg_q);
          end
          if (wb) begin
            step_q <= step_q + 3'd1;
            if (step_q == STEP_THR_LO) begin
              state_q <= ST_FIN;
            end
            unique case (step_q)
              STEP_DC:   dc_q   <= dc_q + ppd_pkg::MUL_A_W'(acc >>> 24);
              STEP_LOW:  low_q  <= ppd_pkg::sat32(48'(low_q) + 48'(acc >>> 16));
              STEP_DAMP: ;
              STEP_BAND: band_q <= ppd_pkg::sat32(48'(band_q) + 48'(acc >>> 16));
              STEP_POS: begin
                up_q  <= (y > pos_q);
                pos_q <= (y > pos_q) ? y : 32'(ppd_pkg::ACC_W'(pos_q) - (acc >>> 20));
              end
              STEP_NEG: begin
                dn_q  <= (y < neg_q);
                neg_q <= (y < neg_q) ? y : 32'(ppd_pkg::ACC_W'(neg_q) - (acc >>> 20));
              end
              STEP_THR_HI: hi_q <= (ppd_pkg::ACC_W'($signed({y, 16'd0})) > acc);
              default:     lo_q <= (ppd_pkg::ACC_W'($signed({y, 16'd0})) < acc);
            endcase
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            state_q <= ST_IDLE;
            cnt_q   <= cnt_d;
            pv_q    <= pv_d;
            prev_q  <= prev_d;
            count_q <= count_d;
            sum_q   <= sum_d;
            pulse_q <= pulse_d;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (fin_go) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      filtered_o     <= filt_w;
      amplitude_o    <= amp_q;
      period_o       <= pv_d;
      edge_taken_o   <= edge_w;
      period_count_o <= count_d;
      period_sum_o   <= sum_d;
    end
  end

  `ASSERT_IMPL(a_cnt_cap, 1'b1, cnt_q <= CW'(ppd_pkg::MAX_PERIOD), "period counter past cap")
  `ASSERT_NEXT(a_edge_restart, fin_go && edge_w, cnt_q == CW'(1), "edge did not restart counter")
  `ASSERT_NEXT(a_accept_run, accept, state_q == ST_RUN && step_q == STEP_DC && ph_q == PH_LO, "transfer did not start sequence")

endmodule

>>> dv/testbench.sv
// Self-checking testbench of pitch_period_detector: drives ADC samples and
// configuration writes and checks each result against a cycle-free predictor or a typed result.
// Depends on rtl/ppd_pkg.sv and the pitch_period_detector RTL.
module testbench;

  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam int LIMIT = 4000000;
  localparam int DRAIN = 40;

  typedef struct packed {
    logic signed [15:0] filtered;
    logic [15:0]        amplitude;
    logic [12:0]        period;
    logic               edge_taken;
    logic [15:0]        period_count;
    logic [27:0]        period_sum;
  } pitch_result_t;

  typedef struct {
    logic [11:0]   sample;
    logic          restart;
    bit            typed;
    pitch_result_t res;
  } stim_row_t;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [11:0] sample = '0;
  logic restart = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [15:0] filtered;
  logic [15:0] amplitude;
  logic [12:0] period;
  logic edge_taken;
  logic [15:0] period_count;
  logic [27:0] period_sum;
  logic cfg_we = 0;
  logic [2:0] cfg_idx = '0;
  logic [19:0] cfg_wdata = '0;

  pitch_period_detector dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .sample_i(sample), .restart_i(restart),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .filtered_o(filtered), .amplitude_o(amplitude), .period_o(period),
    .edge_taken_o(edge_taken), .period_count_o(period_count),
    .period_sum_o(period_sum),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  // predictor state and registers
  longint unsigned coef_r, damp_r, bp_r, min_amp_r, thr_r, decay_r, min_per_r;
  longint dc_acc, band_acc, low_acc, env_hi, env_lo;
  longint unsigned amp_hold, pulse_on, per_cnt, per_val, per_prev, cons_cnt, cons_sum;

  pitch_result_t pending_q[$];
  int errors = 0;
  int cycles = 0;
  bit hold_req = 0;
  int burst_left = 1;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned env_span();
    longint a;
    a = (env_hi - env_lo) >>> 12;
    if (a < 0) a = 0;
    if (a > 65535) a = 65535;
    return a;
  endfunction

  function automatic pitch_result_t pitch_step(logic [11:0] s, logic r);
    longint x, hp, hp12, y, lim;
    longint unsigned d;
    pitch_result_t o;
    o.edge_taken = 1'b0;
    x = longint'(s);
    if (r) begin
      per_prev = 0; cons_cnt = 0; cons_sum = 0;
    end
    hp = (x <<< 24) - dc_acc;
    dc_acc += (hp * longint'(ppd_pkg::DC_LEAK)) >>> 24;
    hp12 = hp >>> 12;
    low_acc = clip32(low_acc + ((longint'(coef_r) * band_acc) >>> 16));
    band_acc = clip32(band_acc + ((longint'(coef_r) *
               (hp12 - ((band_acc * longint'(damp_r)) >>> 14) - low_acc)) >>> 16));
    y = bp_r ? band_acc : low_acc;
    if (y > env_hi) begin
      env_hi = y; amp_hold = env_span();
    end else begin
      env_hi -= (env_hi * longint'(decay_r)) >>> 20;
    end
    if (y < env_lo) begin
      env_lo = y; amp_hold = env_span();
    end else begin
      env_lo -= (env_lo * longint'(decay_r)) >>> 20;
    end
    if (y * 65536 > env_hi * longint'(thr_r)) begin
      if (pulse_on == 0 && per_cnt >= min_per_r) begin
        if (amp_hold > min_amp_r) begin
          per_val = per_cnt;
          d = per_prev > per_val ? per_prev - per_val : per_val - per_prev;
          if (d < ppd_pkg::PERIOD_TOL) begin
            cons_sum = (cons_sum + per_val > ppd_pkg::SUM_MAX) ? ppd_pkg::SUM_MAX
                       : cons_sum + per_val;
            if (cons_cnt < ppd_pkg::COUNT_MAX) cons_cnt++;
          end
          per_prev = per_val;
        end else begin
          per_val = 0;
        end
        per_cnt = 0;
        o.edge_taken = 1'b1;
      end
      pulse_on = 1;
    end
    if (y * 65536 < env_lo * longint'(thr_r)) pulse_on = 0;
    if (per_cnt < ppd_pkg::MAX_PERIOD) per_cnt++;
    else per_val = 0;
    lim = y >>> 12;
    if (lim > 32767) lim = 32767;
    if (lim < -32768) lim = -32768;
    o.filtered = lim[15:0];
    o.amplitude = amp_hold[15:0];
    o.period = per_val[12:0];
    o.period_count = cons_cnt[15:0];
    o.period_sum = cons_sum[27:0];
    return o;
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: long hold-off on request, otherwise a changing stall pattern
  initial begin
    int hold_cnt;
    int mode;
    hold_cnt = 0;
    mode = 0;
    forever begin
      @(posedge clk_i);
      if (cycles % 256 == 0) mode = $urandom_range(0, 3);
      if (hold_req && hold_cnt == 0) hold_cnt = 400;
      if (hold_cnt > 0) begin
        out_ready <= 0;
        hold_cnt--;
        if (hold_cnt == 0) hold_req = 0;
      end else begin
        case (mode)
          0: out_ready <= 1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 9) != 0);
          default: out_ready <= (cycles % 8 < 3);
        endcase
      end
    end
  end

  function automatic void check_field(string name, longint unsigned e, longint unsigned a);
    if (e != a) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
    end
  endfunction

  always @(posedge clk_i) begin
    pitch_result_t e;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got filtered %0h", $time, filtered);
      end else begin
        e = pending_q.pop_front();
        check_field("filtered", e.filtered, filtered);
        check_field("amplitude", e.amplitude, amplitude);
        check_field("period", e.period, period);
        check_field("edge_taken", e.edge_taken, edge_taken);
        check_field("period_count", e.period_count, period_count);
        check_field("period_sum", e.period_sum, period_sum);
      end
    end
  end

  task automatic send(logic [11:0] s, logic r, bit typed = 0,
                      pitch_result_t tres = '0);
    pitch_result_t p;
    int gap;
    in_valid <= 1;
    sample <= s;
    restart <= r;
    do @(posedge clk_i); while (!in_ready);
    p = pitch_step(s, r);
    pending_q.push_back(typed ? tres : p);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic set_reg(logic [2:0] idx, logic [19:0] val);
    in_valid <= 0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 0;
    case (idx)
      ppd_pkg::CFG_FILTER_COEF: coef_r = val & 20'hFFFF;
      ppd_pkg::CFG_DAMPING:     damp_r = val & 20'h7FFF;
      ppd_pkg::CFG_BANDPASS:    bp_r = val & 20'h1;
      ppd_pkg::CFG_MIN_AMP:     min_amp_r = val & 20'hFFF;
      ppd_pkg::CFG_ENV_THR:     thr_r = val & 20'hFFFF;
      ppd_pkg::CFG_ENV_DECAY:   decay_r = val & 20'hFFFFF;
      ppd_pkg::CFG_MIN_PERIOD:  min_per_r = val & 20'h1FFF;
      default: ;
    endcase
  endtask

  task automatic set_all(int c, int dm, int bp, int ma, int th, int dc, int mp);
    set_reg(ppd_pkg::CFG_FILTER_COEF, 20'(c));
    set_reg(ppd_pkg::CFG_DAMPING, 20'(dm));
    set_reg(ppd_pkg::CFG_BANDPASS, 20'(bp));
    set_reg(ppd_pkg::CFG_MIN_AMP, 20'(ma));
    set_reg(ppd_pkg::CFG_ENV_THR, 20'(th));
    set_reg(ppd_pkg::CFG_ENV_DECAY, 20'(dc));
    set_reg(ppd_pkg::CFG_MIN_PERIOD, 20'(mp));
  endtask

  // periodic waveforms with random shape, size and noise, some raw noise
  task automatic send_waves(int n);
    int per, amp, noise, shape, ph, v, left;
    left = 0; per = 100; amp = 0; noise = 0; shape = 0; ph = 0;
    for (int i = 0; i < n; i++) begin
      if (left == 0) begin
        left = $urandom_range(100, 600);
        per = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 40) : $urandom_range(40, 400);
        amp = $urandom_range(0, 2047);
        noise = $urandom_range(0, 3) == 0 ? $urandom_range(0, 200) : 0;
        shape = $urandom_range(0, 2);
        ph = 0;
      end
      left--;
      ph = (ph + 1) % per;
      case (shape)
        0: v = (ph < per / 2) ? 2048 + amp : 2048 - amp;
        1: v = 2048 - amp + (4 * amp * ((ph < per / 2) ? ph : per - ph)) / per;
        default: v = 2048 - amp + (2 * amp * ph) / per;
      endcase
      if (noise > 0) v += $urandom_range(0, 2 * noise) - noise;
      if ($urandom_range(0, 15) == 0) v = $urandom_range(0, 4095);
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      send(12'(v), $urandom_range(0, 99) == 0);
    end
  endtask

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    coef_r = 4096; damp_r = 8192; bp_r = 0; min_amp_r = 100;
    thr_r = 52429; decay_r = 1820; min_per_r = 48;
    dc_acc = 0; band_acc = 0; low_acc = 0; env_hi = 0; env_lo = 0;
    amp_hold = 0; pulse_on = 0; per_cnt = 0; per_val = 0; per_prev = 0;
    cons_cnt = 0; cons_sum = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // zero input after reset leaves every output at zero; then steps, patterns and a full-scale square wave
    rows.push_back('{12'd0, 1'b0, 1, '0});
    rows.push_back('{12'd0, 1'b1, 1, '0});
    rows.push_back('{12'd4095, 1'b0, 0, '0});
    rows.push_back('{12'd4095, 1'b0, 0, '0});
    rows.push_back('{12'd0, 1'b0, 0, '0});
    rows.push_back('{12'd0, 1'b1, 0, '0});
    rows.push_back('{12'hAAA, 1'b0, 0, '0});
    rows.push_back('{12'h555, 1'b0, 0, '0});
    for (int i = 0; i < 12; i++) rows.push_back('{(i % 2) ? 12'd4095 : 12'd0, 1'b0, 0, '0});
    foreach (rows[i]) begin
      row = rows[i];
      send(row.sample, row.restart, row.typed, row.res);
    end

    // defaults, with a long receiver hold-off while the sender keeps going
    set_all(4096, 8192, 0, 100, 52429, 1820, 48);
    hold_req = 1;
    send_waves(400);
    set_reg(CFG_UNUSED, 20'($urandom_range(0, 20'hFFFFF)));
    set_all(8000, 4000, 1, 20, 40000, 5000, 10);
    send_waves(350);
    // unstable filter, zero minimum period, no decay
    set_all(65535, 0, 0, 0, 65535, 0, 0);
    send_waves(250);
    set_all(0, 32767, 1, 4095, 0, 1048575, 4096);
    send_waves(200);
    set_all(3000, 8192, 0, 0, 52429, 1820, 1);
    send_waves(300);
    for (int k = 0; k < 3; k++) begin
      set_all($urandom_range(500, 20000), $urandom_range(0, 32767), $urandom_range(0, 1),
              $urandom_range(0, 4095), $urandom_range(0, 65535),
              $urandom_range(0, 1048575), $urandom_range(0, 200));
      send_waves(150);
    end
    in_valid <= 0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/ppd_pkg.sv
rtl/ppd_mac.sv
rtl/pitch_period_detector.sv
dv/testbench.sv
